// ===== rtl/core/r3nt_pkg.sv =====
package r3nt_pkg;

    // default word width of residues and modulus
    localparam int WORD_BITS_DEF = 32;

    // configuration register indexes
    localparam int REG_INDEX_BITS = 2;
    localparam logic [REG_INDEX_BITS-1:0] REG_MODULUS        = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEFF_ONE      = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_COEFF_TWO      = 2'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_TWIDDLE_ENABLE = 2'd3;

    // lanes of the input reduction pipe
    localparam int RED_LANES = 7;

endpackage

// ===== rtl/core/r3nt_mulmod_pipe.sv =====
// pipelined shift-add modular multiplier, one multiplier bit per stage
module r3nt_mulmod_pipe
    import r3nt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int LANES     = 2,
    parameter int SIDE_BITS = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             in_valid,
    input  logic [LANES-1:0][WORD_BITS-1:0]  in_a,
    input  logic [LANES-1:0][WORD_BITS-1:0]  in_b,
    input  logic [WORD_BITS-1:0]             modulus,
    input  logic [SIDE_BITS-1:0]             in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][WORD_BITS-1:0]  out_prod,
    output logic [SIDE_BITS-1:0]             out_side
);

    localparam int STAGES = WORD_BITS;

    logic                             valid_reg [STAGES];
    logic [LANES-1:0][WORD_BITS-1:0]  acc_reg  [STAGES];
    logic [LANES-1:0][WORD_BITS-1:0]  a_reg    [STAGES];
    logic [LANES-1:0][WORD_BITS-1:0]  b_reg    [STAGES];
    logic [SIDE_BITS-1:0]             side_reg [STAGES];

    genvar s, l;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic                            valid_next;
            logic [LANES-1:0][WORD_BITS-1:0] acc_in;
            logic [LANES-1:0][WORD_BITS-1:0] a_next;
            logic [LANES-1:0][WORD_BITS-1:0] b_in;
            logic [LANES-1:0][WORD_BITS-1:0] acc_next;
            logic [LANES-1:0][WORD_BITS-1:0] b_next;
            logic [SIDE_BITS-1:0]            side_next;

            if (s == 0) begin : g_first
                assign valid_next = in_valid;
                assign acc_in     = '0;
                assign a_next     = in_a;
                assign b_in       = in_b;
                assign side_next  = in_side;
            end
            else begin : g_rest
                assign valid_next = valid_reg[s-1];
                assign acc_in     = acc_reg[s-1];
                assign a_next     = a_reg[s-1];
                assign b_in       = b_reg[s-1];
                assign side_next  = side_reg[s-1];
            end

            for (l = 0; l < LANES; l++) begin : g_lane
                // acc = 2*acc + bit*a, reduced after each add
                always_comb
                begin
                    logic [WORD_BITS:0] dbl;
                    logic [WORD_BITS:0] sum;
                    dbl = {acc_in[l], 1'b0};
                    if (dbl >= {1'b0, modulus})
                    begin
                        dbl = dbl - {1'b0, modulus};
                    end
                    sum = dbl + (b_in[l][WORD_BITS-1] ? {1'b0, a_next[l]} : '0);
                    if (sum >= {1'b0, modulus})
                    begin
                        sum = sum - {1'b0, modulus};
                    end
                    acc_next[l] = sum[WORD_BITS-1:0];
                    b_next[l]   = {b_in[l][WORD_BITS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[s] <= valid_next;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    acc_reg[s]  <= acc_next;
                    a_reg[s]    <= a_next;
                    b_reg[s]    <= b_next;
                    side_reg[s] <= side_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_prod  = acc_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== rtl/core/radix3_ntt_twiddle_butterfly.sv =====
// throughput: one butterfly per cycle while the output is not stalled; uses three
//   WORD_BITS-stage shift-add modular multiplier pipes (input reduction, constants, twiddles)
// a stalled output freezes the whole pipe; in_ready = !out_valid || out_ready
// reset: asynchronous active low; clears all valid bits and loads the config
//   registers with modulus 3, zero coefficients, twiddle off
module radix3_ntt_twiddle_butterfly
    import r3nt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [REG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [WORD_BITS-1:0]      x_zero,
    input  logic [WORD_BITS-1:0]      x_one,
    input  logic [WORD_BITS-1:0]      x_two,
    input  logic [WORD_BITS-1:0]      w_one,
    input  logic [WORD_BITS-1:0]      w_two,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [WORD_BITS-1:0]      y_zero,
    output logic [WORD_BITS-1:0]      y_one,
    output logic [WORD_BITS-1:0]      y_two
);

    localparam logic [WORD_BITS-1:0] ONE_WORD = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] TWO_WORD = WORD_BITS'(2);

    // modular add and subtract, operands already below m
    function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] sub_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        // a - b + m wraps back into range when a < b
        return (a >= b) ? (a - b) : (a - b + m);
    endfunction

    // configuration registers
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] coeff_one_reg;
    logic [WORD_BITS-1:0] coeff_two_reg;
    logic                 twiddle_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg        <= WORD_BITS'(3);
            coeff_one_reg      <= '0;
            coeff_two_reg      <= '0;
            twiddle_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS:        modulus_reg        <= cfg_data;
                REG_COEFF_ONE:      coeff_one_reg      <= cfg_data;
                REG_COEFF_TWO:      coeff_two_reg      <= cfg_data;
                REG_TWIDDLE_ENABLE: twiddle_enable_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // whole pipe moves together; it only holds when the output is blocked
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // modulus below two forces an all-zero result; flag rides with the item
    logic tiny_mod;
    assign tiny_mod = modulus_reg < TWO_WORD;

    // stage group 1: reduce every operand mod m as 1*x mod m
    logic [RED_LANES-1:0][WORD_BITS-1:0] red_a;
    logic [RED_LANES-1:0][WORD_BITS-1:0] red_b;
    logic [RED_LANES-1:0][WORD_BITS-1:0] red_out;
    logic                                red_valid;
    logic                                red_tiny;

    assign red_a = {RED_LANES{ONE_WORD}};
    assign red_b = {coeff_two_reg, coeff_one_reg, w_two, w_one, x_two, x_one, x_zero};

    r3nt_mulmod_pipe #(
        .WORD_BITS (WORD_BITS),
        .LANES     (RED_LANES),
        .SIDE_BITS (1)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid && in_ready),
        .in_a      (red_a),
        .in_b      (red_b),
        .modulus   (modulus_reg),
        .in_side   (tiny_mod),
        .out_valid (red_valid),
        .out_prod  (red_out),
        .out_side  (red_tiny)
    );

    // stage a1: sum and difference of x1, x2
    logic                 a1_valid_reg;
    logic                 a1_tiny_reg;
    logic [WORD_BITS-1:0] a1_x0_reg, a1_t1_reg, a1_t2_reg;
    logic [WORD_BITS-1:0] a1_w1_reg, a1_w2_reg, a1_c1_reg, a1_c2_reg;

    // stage a2: y0 = x0 + t1
    logic                 a2_valid_reg;
    logic                 a2_tiny_reg;
    logic [WORD_BITS-1:0] a2_y0_reg, a2_t1_reg, a2_t2_reg;
    logic [WORD_BITS-1:0] a2_w1_reg, a2_w2_reg, a2_c1_reg, a2_c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a1_valid_reg <= red_valid;
            a2_valid_reg <= a1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_tiny_reg <= red_tiny;
            a1_x0_reg   <= red_out[0];
            a1_t1_reg   <= add_mod(red_out[1], red_out[2], modulus_reg);
            a1_t2_reg   <= sub_mod(red_out[1], red_out[2], modulus_reg);
            a1_w1_reg   <= red_out[3];
            a1_w2_reg   <= red_out[4];
            a1_c1_reg   <= red_out[5];
            a1_c2_reg   <= red_out[6];

            a2_tiny_reg <= a1_tiny_reg;
            a2_y0_reg   <= add_mod(a1_x0_reg, a1_t1_reg, modulus_reg);
            a2_t1_reg   <= a1_t1_reg;
            a2_t2_reg   <= a1_t2_reg;
            a2_w1_reg   <= a1_w1_reg;
            a2_w2_reg   <= a1_w2_reg;
            a2_c1_reg   <= a1_c1_reg;
            a2_c2_reg   <= a1_c2_reg;
        end
    end

    // stage group 2: t1*c1 and t2*c2, carrying y0 and the twiddles
    localparam int COEF_SIDE = 3 * WORD_BITS + 1;

    logic [1:0][WORD_BITS-1:0] coef_out;
    logic [COEF_SIDE-1:0]      coef_side;
    logic                      coef_valid;

    r3nt_mulmod_pipe #(
        .WORD_BITS (WORD_BITS),
        .LANES     (2),
        .SIDE_BITS (COEF_SIDE)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (a2_valid_reg),
        .in_a      ({a2_t2_reg, a2_t1_reg}),
        .in_b      ({a2_c2_reg, a2_c1_reg}),
        .modulus   (modulus_reg),
        .in_side   ({a2_tiny_reg, a2_y0_reg, a2_w2_reg, a2_w1_reg}),
        .out_valid (coef_valid),
        .out_prod  (coef_out),
        .out_side  (coef_side)
    );

    // stage b1: q = y0 + t1*c1
    logic                 b1_valid_reg;
    logic                 b1_tiny_reg;
    logic [WORD_BITS-1:0] b1_y0_reg, b1_q_reg, b1_r_reg, b1_w1_reg, b1_w2_reg;

    // stage b2: y1 = q + r, y2 = q - r
    logic                 b2_valid_reg;
    logic                 b2_tiny_reg;
    logic [WORD_BITS-1:0] b2_y0_reg, b2_y1_reg, b2_y2_reg, b2_w1_reg, b2_w2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg <= coef_valid;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_tiny_reg <= coef_side[3*WORD_BITS];
            b1_y0_reg   <= coef_side[3*WORD_BITS-1:2*WORD_BITS];
            b1_q_reg    <= add_mod(coef_side[3*WORD_BITS-1:2*WORD_BITS], coef_out[0],
                                   modulus_reg);
            b1_r_reg    <= coef_out[1];
            b1_w2_reg   <= coef_side[2*WORD_BITS-1:WORD_BITS];
            b1_w1_reg   <= coef_side[WORD_BITS-1:0];

            b2_tiny_reg <= b1_tiny_reg;
            b2_y0_reg   <= b1_y0_reg;
            b2_y1_reg   <= add_mod(b1_q_reg, b1_r_reg, modulus_reg);
            b2_y2_reg   <= sub_mod(b1_q_reg, b1_r_reg, modulus_reg);
            b2_w1_reg   <= b1_w1_reg;
            b2_w2_reg   <= b1_w2_reg;
        end
    end

    // stage group 3: twiddle multiply; with twiddles off multiply by one
    localparam int TW_SIDE = WORD_BITS + 1;

    logic [1:0][WORD_BITS-1:0] tw_b;
    logic [1:0][WORD_BITS-1:0] tw_out;
    logic [TW_SIDE-1:0]        tw_side;
    logic                      tw_valid;

    assign tw_b = twiddle_enable_reg ? {b2_w2_reg, b2_w1_reg} : {ONE_WORD, ONE_WORD};

    r3nt_mulmod_pipe #(
        .WORD_BITS (WORD_BITS),
        .LANES     (2),
        .SIDE_BITS (TW_SIDE)
    ) u_twiddle (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (b2_valid_reg),
        .in_a      ({b2_y2_reg, b2_y1_reg}),
        .in_b      (tw_b),
        .modulus   (modulus_reg),
        .in_side   ({b2_tiny_reg, b2_y0_reg}),
        .out_valid (tw_valid),
        .out_prod  (tw_out),
        .out_side  (tw_side)
    );

    // output register
    logic [WORD_BITS-1:0] y_zero_reg, y_one_reg, y_two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y_zero_reg <= tw_side[WORD_BITS] ? '0 : tw_side[WORD_BITS-1:0];
            y_one_reg  <= tw_side[WORD_BITS] ? '0 : tw_out[0];
            y_two_reg  <= tw_side[WORD_BITS] ? '0 : tw_out[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign y_zero    = y_zero_reg;
    assign y_one     = y_one_reg;
    assign y_two     = y_two_reg;

endmodule

// ===== rtl/core/r3nt_checker.sv =====
module r3nt_checker
    import r3nt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [WORD_BITS-1:0]      y_zero,
    input logic [WORD_BITS-1:0]      y_one,
    input logic [WORD_BITS-1:0]      y_two
);

    // stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(y_zero) && $stable(y_one)
                                    && $stable(y_two))
        else $error("stalled result changed");

    // input side is held exactly when the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // nothing comes out right after reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result shown right after reset");

endmodule

bind radix3_ntt_twiddle_butterfly r3nt_checker #(.WORD_BITS(WORD_BITS)) u_r3nt_checker (.*);

// ===== sim/radix3_ntt_twiddle_butterfly_checker.sv =====
`timescale 1ns / 1ps

module radix3_ntt_twiddle_butterfly_checker
    import r3nt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [REG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [31:0]               x_zero,
    input  logic [31:0]               x_one,
    input  logic [31:0]               x_two,
    input  logic [31:0]               w_one,
    input  logic [31:0]               w_two,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [31:0]               y_zero,
    input  logic [31:0]               y_one,
    input  logic [31:0]               y_two,
    output int                        fail_count,
    output int                        pending,
    output int                        butterflies_seen
);

    typedef struct packed {
        logic [31:0] y0;
        logic [31:0] y1;
        logic [31:0] y2;
    } residues_t;

    logic [31:0] prime;
    logic [31:0] c_sum;
    logic [31:0] c_diff;
    logic        tw_on;
    residues_t   expected_q[$];

    function automatic logic [63:0] addm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic logic [63:0] subm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a * b) % m;
    endfunction

    function automatic residues_t butterfly(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                            logic [31:0] b1, logic [31:0] b2);
        logic [63:0] m, x0, x1, x2, w1, w2, k1, k2, t1, t2, s0, q, r, s1, s2;
        residues_t res;
        m = {32'd0, prime};
        if (m < 2) return '0;
        x0 = a0 % m; x1 = a1 % m; x2 = a2 % m;
        w1 = b1 % m; w2 = b2 % m;
        k1 = c_sum % m; k2 = c_diff % m;
        t1 = addm(x1, x2, m);
        t2 = subm(x1, x2, m);
        s0 = addm(x0, t1, m);
        q  = addm(s0, mulm(t1, k1, m), m);
        r  = mulm(t2, k2, m);
        s1 = addm(q, r, m);
        s2 = subm(q, r, m);
        if (tw_on)
        begin
            s1 = mulm(s1, w1, m);
            s2 = mulm(s2, w2, m);
        end
        res.y0 = s0[31:0]; res.y1 = s1[31:0]; res.y2 = s2[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        residues_t want;
        if (!rst_n)
        begin
            prime = 32'd3; c_sum = '0; c_diff = '0; tw_on = 1'b0;
            expected_q.delete();
            fail_count = 0;
            butterflies_seen = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(butterfly(x_zero, x_one, x_two, w_one, w_two));
            if (out_valid && out_ready)
            begin
                butterflies_seen++;
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected result transfer, y_zero", y_zero, '0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (y_zero !== want.y0) report_mismatch("y_zero", y_zero, want.y0);
                    if (y_one !== want.y1) report_mismatch("y_one", y_one, want.y1);
                    if (y_two !== want.y2) report_mismatch("y_two", y_two, want.y2);
                end
            end
            if (cfg_write)
                case (cfg_index)
                    REG_MODULUS:        prime = cfg_data;
                    REG_COEFF_ONE:      c_sum = cfg_data;
                    REG_COEFF_TWO:      c_diff = cfg_data;
                    REG_TWIDDLE_ENABLE: tw_on = cfg_data[0];
                    default: ;
                endcase
            pending = expected_q.size();
        end
    end

endmodule

// ===== sim/radix3_ntt_twiddle_butterfly_tb.sv =====
`timescale 1ns / 1ps

module radix3_ntt_twiddle_butterfly_tb;
    import r3nt_pkg::*;

    localparam int LATENCY   = 3 * 32 + 4;
    localparam int WATCH_MAX = 4000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [REG_INDEX_BITS-1:0] cfg_index;
    logic [31:0]               cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [31:0]               x_zero, x_one, x_two, w_one, w_two;
    logic                      out_valid;
    logic                      out_ready;
    logic [31:0]               y_zero, y_one, y_two;

    int  fail_count;
    int  pending;
    int  butterflies_seen;
    int  quiet_cycles;
    bit  steady;        // no idling on either side
    logic [31:0] cur_mod;

    radix3_ntt_twiddle_butterfly uut (.*);

    radix3_ntt_twiddle_butterfly_checker chk (.*);

    // free-running clock, 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver side: random backpressure except during steady stretches
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);

    // watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // write strobe stays up until the next send drops it
    task automatic write_reg(logic [REG_INDEX_BITS-1:0] idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        if (idx == REG_MODULUS) cur_mod = val;
    endtask

    // drain all outstanding results, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // one butterfly transfer; valid held until accepted
    task automatic send(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                        logic [31:0] b1, logic [31:0] b2);
        cfg_write <= 1'b0;
        if (!steady)
            while ($urandom_range(0, 99) < 33)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        x_zero <= a0; x_one <= a1; x_two <= a2; w_one <= b1; w_two <= b2;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // residue mostly below the modulus, sometimes unreduced
    function automatic logic [31:0] pick();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom();
        if (sel == 1) return (cur_mod == 0) ? 32'd0 : cur_mod - 1;
        if (cur_mod == 0) return $urandom();
        return $urandom() % cur_mod;
    endfunction

    task automatic random_run(int n);
        repeat (n) send(pick(), pick(), pick(), pick(), pick());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0;
        x_zero = '0; x_one = '0; x_two = '0; w_one = '0; w_two = '0;
        out_ready = 1'b0;
        steady = 1'b0;
        quiet_cycles = 0;
        cur_mod = 32'd3;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset configuration: modulus 3, operands unreduced
        send(32'd0, 32'd1, 32'd2, 32'd0, 32'd0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5, 32'd7, 32'd8);
        wait_idle();

        // largest 32-bit prime, twiddles on, extreme coefficients
        write_reg(REG_MODULUS, 32'hFFFF_FFFB);
        write_reg(REG_COEFF_ONE, 32'hFFFF_FFFA);
        write_reg(REG_COEFF_TWO, 32'hFFFF_FFFF);
        write_reg(REG_TWIDDLE_ENABLE, 32'd1);
        send(32'hFFFF_FFFA, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 32'hFFFF_FFFA);
        send(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send(32'd0, 32'd0, 32'hFFFF_FFFA, 32'd1, 32'd1);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'hFFFF_FFFB);
        send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // degenerate moduli give all-zero results
        write_reg(REG_MODULUS, 32'd0);
        send(32'd9, 32'd8, 32'd7, 32'd6, 32'd5);
        wait_idle();
        write_reg(REG_MODULUS, 32'd1);
        send(32'hFFFF_FFFF, 32'd1, 32'd2, 32'd3, 32'd4);
        wait_idle();
        // even and composite moduli, twiddle off
        write_reg(REG_MODULUS, 32'hFFFF_FFFF);
        write_reg(REG_TWIDDLE_ENABLE, 32'd0);
        send(32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd3);
        wait_idle();
        write_reg(REG_MODULUS, 32'd2);
        send(32'd1, 32'd1, 32'd0, 32'd1, 32'd1);
        wait_idle();

        // random phases across several settings
        write_reg(REG_MODULUS, 32'hFFFF_FFFB);
        write_reg(REG_COEFF_ONE, $urandom());
        write_reg(REG_COEFF_TWO, $urandom());
        write_reg(REG_TWIDDLE_ENABLE, 32'd1);
        random_run(200);
        steady = 1'b1;
        random_run(150);
        steady = 1'b0;
        wait_idle();

        write_reg(REG_MODULUS, 32'd7681);
        write_reg(REG_COEFF_ONE, 32'd7680);
        write_reg(REG_COEFF_TWO, 32'd0);
        write_reg(REG_TWIDDLE_ENABLE, 32'd0);
        random_run(120);
        wait_idle();

        write_reg(REG_MODULUS, 32'hFFFF_FFFF);
        write_reg(REG_COEFF_ONE, $urandom());
        write_reg(REG_COEFF_TWO, $urandom());
        write_reg(REG_TWIDDLE_ENABLE, 32'd1);
        random_run(120);
        wait_idle();

        write_reg(REG_MODULUS, 32'd3);
        write_reg(REG_COEFF_ONE, 32'd2);
        write_reg(REG_COEFF_TWO, 32'd1);
        random_run(100);
        wait_idle();

        $display("%0d butterflies checked over prime, composite, even and degenerate moduli",
                 butterflies_seen);
        $display("twiddles on and off, unreduced operands, random stalls on both channels");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
